// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the framer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/sbpf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_pkg
// opcodes, instruction codes and result kinds of the servo bus packet framer
// ----------------------------------------------------------------------------
package sbpf_pkg;

	// item opcodes
	localparam logic [2:0] OP_WRITE     = 3'd0;
	localparam logic [2:0] OP_READ      = 3'd1;
	localparam logic [2:0] OP_REG_WRITE = 3'd2;
	localparam logic [2:0] OP_ACTION    = 3'd3;
	localparam logic [2:0] OP_PING      = 3'd4;
	localparam logic [2:0] OP_RESET     = 3'd5;
	localparam logic [2:0] OP_RX        = 3'd6;
	// opcode the framer has no use for
	localparam logic [2:0] OP_UNUSED    = 3'd7;

	// instruction bytes on the bus
	localparam logic [7:0] INSTR_PING      = 8'h01;
	localparam logic [7:0] INSTR_READ      = 8'h02;
	localparam logic [7:0] INSTR_WRITE     = 8'h03;
	localparam logic [7:0] INSTR_REG_WRITE = 8'h04;
	localparam logic [7:0] INSTR_ACTION    = 8'h05;
	localparam logic [7:0] INSTR_RESET     = 8'h06;

	localparam logic [7:0] HEADER_BYTE = 8'hFF;
	localparam logic [7:0] ID_BCAST    = 8'hFE;

	// longest packet in bytes
	localparam int unsigned PKT_MAX = 9;

	// result kinds
	localparam logic [1:0] KIND_TX   = 2'd0;
	localparam logic [1:0] KIND_READ = 2'd1;
	localparam logic [1:0] KIND_PING = 2'd2;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_READ = 2'd1,
		MODE_PING = 2'd2
	} reply_mode_t;

	typedef logic [7:0] byte_t;

endpackage

// ===== sv/sbpf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_in_if
// command and received-byte channel of the packet framer
// ----------------------------------------------------------------------------
interface sbpf_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] opcode;
	logic [7:0] motor_id;
	logic [7:0] reg_addr;
	logic [1:0] param_count;
	logic [7:0] param_lo;
	logic [7:0] param_hi;
	logic [7:0] rx_data;

	modport source (
		output valid, opcode, motor_id, reg_addr, param_count, param_lo, param_hi, rx_data,
		input  ready
	);

	modport sink (
		input  valid, opcode, motor_id, reg_addr, param_count, param_lo, param_hi, rx_data,
		output ready
	);
endinterface

// ===== sv/sbpf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbpf_out_if
// result channel of the packet framer: packet bytes and reply reports
// ----------------------------------------------------------------------------
interface sbpf_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  tx_byte;
	logic        last;
	logic [7:0]  reply_id;
	logic [15:0] read_value;
	logic        read_ok;

	modport source (
		output valid, kind, tx_byte, last, reply_id, read_value, read_ok,
		input  ready
	);

	modport sink (
		input  valid, kind, tx_byte, last, reply_id, read_value, read_ok,
		output ready
	);
endinterface

// ===== sv/servo_bus_packet_framer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_bus_packet_framer
// frames instruction packets for a half-duplex servo bus and decodes replies
// ----------------------------------------------------------------------------
// usage
//   in_ch takes one item per handshake: a command (write, read, reg write,
//   action, ping, reset) or one byte received from the bus
//   a command produces its whole instruction packet on out_ch, one byte per
//   item, last marking the checksum byte; read and ping arm the reply decoder
//   received bytes are counted; the final reply byte produces one report item
//   (read or ping) with the reply id, and for a read the value and the checksum match flag
// timing
//   the first result of an accepted item is loaded into the work register and
//   then moves into the output register once out_ch can take it
//   a packet of 6 to 9 bytes holds the packet shift line until its last byte
//   moves out; the next item is taken in the cycle the last byte moves out,
//   so a steady command stream runs at one byte per cycle while out_ch is
//   ready; only commands and final reply bytes occupy the work register
// reset
//   clears the reply decoder (no reply armed), the shift line and out_ch
// stall
//   out_ch holds its item while ready is low; the shift line keeps the next
//   byte, and in_ch drops ready once the shift line is still busy
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module servo_bus_packet_framer
	import sbpf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	sbpf_in_if.sink    in_ch,
	sbpf_out_if.source out_ch
);

	// reply decoder state
	reply_mode_t reply_mode_q;
	logic [3:0]  reply_index_q;
	logic [3:0]  reply_length_q;
	logic [7:0]  reply_sum_q;
	logic [7:0]  reply_id_seen_q;
	logic [7:0]  value_low_q;
	logic [7:0]  value_high_q;
	logic [1:0]  read_width_q;

	// work register: packet shift line or one reply report
	logic        busy_q;
	logic [1:0]  wk_kind_q;
	byte_t       wk_buf_q [PKT_MAX];
	logic [3:0]  wk_rem_q;
	logic [7:0]  wk_rid_q;
	logic [15:0] wk_val_q;
	logic        wk_ok_q;

	// output register
	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [7:0]  out_tx_q;
	logic        out_last_q;
	logic [7:0]  out_rid_q;
	logic [15:0] out_val_q;
	logic        out_ok_q;

	logic emit;
	logic emit_final;
	logic in_acc;
	logic is_cmd;

	// packet build
	byte_t      pkt [PKT_MAX];
	logic [3:0] pkt_len;
	logic [1:0] data_cnt;
	logic [1:0] rd_width;
	logic [7:0] pkt_sum;

	// reply decode
	logic       rx_act;
	logic       rx_done;
	logic [7:0] rx_chk;

	assign emit       = busy_q && (!out_valid_q || out_ch.ready);
	assign emit_final = emit && (wk_rem_q == 4'd1);
	assign in_ch.ready = !busy_q || emit_final;
	assign in_acc     = in_ch.valid && in_ch.ready;
	assign is_cmd     = (in_ch.opcode != OP_RX) && (in_ch.opcode != OP_UNUSED);

	// saturate data count and read width into the legal range
	assign data_cnt = (in_ch.param_count == 2'd3) ? 2'd2 : in_ch.param_count;
	assign rd_width = (in_ch.param_count == 2'd0) ? 2'd1 : data_cnt;

	always_comb begin
		for (int i = 0; i < PKT_MAX; i++) begin
			pkt[i] = '0;
		end
		pkt[0]  = HEADER_BYTE;
		pkt[1]  = HEADER_BYTE;
		pkt[2]  = in_ch.motor_id;
		pkt_len = 4'd6;
		case (in_ch.opcode)
			OP_WRITE, OP_REG_WRITE: begin
				pkt[3]  = 8'd3 + {6'd0, data_cnt};
				pkt[4]  = (in_ch.opcode == OP_WRITE) ? INSTR_WRITE : INSTR_REG_WRITE;
				pkt[5]  = in_ch.reg_addr;
				pkt[6]  = in_ch.param_lo;
				pkt[7]  = in_ch.param_hi;
				pkt_len = 4'd7 + {2'd0, data_cnt};
			end
			OP_READ: begin
				pkt[3]  = 8'd4;
				pkt[4]  = INSTR_READ;
				pkt[5]  = in_ch.reg_addr;
				pkt[6]  = {6'd0, rd_width};
				pkt_len = 4'd8;
			end
			OP_ACTION: begin
				pkt[3] = 8'd2;
				pkt[4] = INSTR_ACTION;
			end
			OP_PING: begin
				pkt[3] = 8'd2;
				pkt[4] = INSTR_PING;
			end
			OP_RESET: begin
				pkt[3] = 8'd2;
				pkt[4] = INSTR_RESET;
			end
			default: begin
				pkt[3] = 8'd0;
			end
		endcase
		// id through the last parameter byte
		pkt_sum = pkt[2] + pkt[3] + pkt[4]
			+ ((pkt_len >= 4'd7) ? pkt[5] : 8'd0)
			+ ((pkt_len >= 4'd8) ? pkt[6] : 8'd0)
			+ ((pkt_len >= 4'd9) ? pkt[7] : 8'd0);
		// checksum overwrites the slot after the last counted byte
		for (int i = 5; i < PKT_MAX; i++) begin
			if (pkt_len == 4'(i + 1)) begin
				pkt[i] = ~pkt_sum;
			end
		end
	end

	assign rx_act  = (in_ch.opcode == OP_RX) && (reply_mode_q != MODE_NONE);
	assign rx_done = rx_act && (({1'b0, reply_index_q} + 5'd1) >= {1'b0, reply_length_q});
	assign rx_chk  = ~reply_sum_q;

	// reply decoder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reply_mode_q    <= MODE_NONE;
			reply_index_q   <= '0;
			reply_length_q  <= '0;
			reply_sum_q     <= '0;
			reply_id_seen_q <= '0;
			value_low_q     <= '0;
			value_high_q    <= '0;
			read_width_q    <= 2'd1;
		end else if (in_acc) begin
			if (is_cmd) begin
				// any command cancels a pending reply
				reply_index_q <= '0;
				reply_sum_q   <= '0;
				if (in_ch.opcode == OP_READ) begin
					reply_mode_q   <= MODE_READ;
					reply_length_q <= 4'd6 + {2'd0, rd_width};
					read_width_q   <= rd_width;
					value_low_q    <= '0;
					value_high_q   <= '0;
				end else if (in_ch.opcode == OP_PING) begin
					reply_mode_q   <= MODE_PING;
					reply_length_q <= 4'd6;
				end else begin
					reply_mode_q   <= MODE_NONE;
				end
			end else if (rx_act) begin
				if (reply_index_q == 4'd2) begin
					reply_id_seen_q <= in_ch.rx_data;
				end
				if (reply_mode_q == MODE_READ && reply_index_q == 4'd5) begin
					value_low_q <= in_ch.rx_data;
				end
				if (reply_mode_q == MODE_READ && reply_index_q == 4'd6
						&& read_width_q == 2'd2) begin
					value_high_q <= in_ch.rx_data;
				end
				if (rx_done) begin
					reply_mode_q  <= MODE_NONE;
					reply_index_q <= '0;
					reply_sum_q   <= '0;
				end else begin
					if (reply_index_q >= 4'd2) begin
						reply_sum_q <= reply_sum_q + in_ch.rx_data;
					end
					reply_index_q <= reply_index_q + 4'd1;
				end
			end
		end
	end

	// work register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			wk_kind_q <= KIND_TX;
			wk_rem_q  <= '0;
		end else if (in_acc) begin
			busy_q <= is_cmd || rx_done;
			if (rx_done) begin
				wk_kind_q <= (reply_mode_q == MODE_READ) ? KIND_READ : KIND_PING;
				wk_rem_q  <= 4'd1;
			end else begin
				wk_kind_q <= KIND_TX;
				wk_rem_q  <= pkt_len;
			end
		end else if (emit) begin
			wk_rem_q <= wk_rem_q - 4'd1;
			if (emit_final) begin
				busy_q <= 1'b0;
			end
		end
	end

	// work register payload: load a packet or a report, shift one byte per emit
	always_ff @(posedge clk) begin
		if (in_acc) begin
			if (rx_done) begin
				for (int i = 0; i < PKT_MAX; i++) begin
					wk_buf_q[i] <= '0;
				end
				wk_rid_q <= reply_id_seen_q;
				if (reply_mode_q == MODE_READ) begin
					wk_val_q <= {(read_width_q == 2'd2) ? value_high_q : 8'd0, value_low_q};
					wk_ok_q  <= (rx_chk == in_ch.rx_data);
				end else begin
					wk_val_q <= '0;
					wk_ok_q  <= 1'b0;
				end
			end else begin
				wk_buf_q <= pkt;
				wk_rid_q <= '0;
				wk_val_q <= '0;
				wk_ok_q  <= 1'b0;
			end
		end else if (emit) begin
			for (int i = 0; i < PKT_MAX - 1; i++) begin
				wk_buf_q[i] <= wk_buf_q[i + 1];
			end
			wk_buf_q[PKT_MAX - 1] <= '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_kind_q <= wk_kind_q;
			out_tx_q   <= (wk_kind_q == KIND_TX) ? wk_buf_q[0] : 8'd0;
			out_last_q <= (wk_kind_q == KIND_TX) && (wk_rem_q == 4'd1);
			out_rid_q  <= wk_rid_q;
			out_val_q  <= wk_val_q;
			out_ok_q   <= wk_ok_q;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.kind       = out_kind_q;
	assign out_ch.tx_byte    = out_tx_q;
	assign out_ch.last       = out_last_q;
	assign out_ch.reply_id   = out_rid_q;
	assign out_ch.read_value = out_val_q;
	assign out_ch.read_ok    = out_ok_q;

	// a report occupies the work register for exactly one emit
	`ASSERT_SAME(a_report_single, clk, arst_n, busy_q && wk_kind_q != KIND_TX, wk_rem_q == 4'd1)
	// an accepted command always leaves a packet in the work register
	`ASSERT_NEXT(a_cmd_loads, clk, arst_n, in_acc && is_cmd, busy_q && wk_kind_q == KIND_TX)
	// reports never carry packet bytes
	`ASSERT_SAME(a_report_clean, clk, arst_n, out_valid_q && out_kind_q != KIND_TX, !out_last_q && out_tx_q == 8'd0)
	// an idle decoder holds no partial count or sum
	`ASSERT_SAME(a_idle_decoder, clk, arst_n, reply_mode_q == MODE_NONE, reply_index_q == 4'd0 && reply_sum_q == 8'd0)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// servo bus packet framer: packets and status replies against a bus model
// ----------------------------------------------------------------------------
// a short table of directed items runs first: broadcast and out-of-range ids,
// each instruction, clipped data and read counts, a ping and a read reply, an
// unused opcode, a stray received byte and a reply cut off by a new command.
// a random part follows: commands, most reads and pings answered by a reply
// byte stream with random content, plus truncated replies and stray items.
// every accepted item runs through a bus model kept here; every output item
// is compared field by field with the oldest entry still due. both sides
// idle at random, and the output is once held off long enough for the
// framer to stall its input.
// ----------------------------------------------------------------------------
module testbench;
	import sbpf_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 340;
	localparam int unsigned IDLE_PCT     = 27;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned TAIL_CYCLES  = 24;
	localparam int unsigned HOLD_CYCLES  = 150;
	localparam int unsigned HOLD_AT      = 100;
	localparam int unsigned CALM_FROM    = 230;
	localparam int unsigned CALM_TO      = 300;

	typedef struct packed {
		logic [2:0] opcode;
		byte_t      motor_id;
		byte_t      reg_addr;
		logic [1:0] param_count;
		byte_t      param_lo;
		byte_t      param_hi;
		byte_t      rx_data;
	} cmd_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		byte_t       tx_byte;
		logic        last;
		byte_t       reply_id;
		logic [15:0] read_value;
		logic        read_ok;
	} bus_item_t;

	// a directed row; n_typed < 0 leaves the expectation to the bus model,
	// otherwise the row carries its packet, first byte leftmost
	typedef struct {
		cmd_item_t   item;
		int          n_typed;
		logic [71:0] pkt;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;

	sbpf_in_if  in_ch ();
	sbpf_out_if out_ch ();

	servo_bus_packet_framer i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// bus model state
	// ------------------------------------------------------------------------
	reply_mode_t reply_mode;
	logic [3:0]  reply_idx;
	logic [3:0]  reply_len;
	byte_t       reply_sum;
	byte_t       seen_id;
	byte_t       value_lo;
	byte_t       value_hi;
	logic [1:0]  read_width;

	bus_item_t   step_items [$];    // what the last accepted item produced
	bus_item_t   bus_items_due [$]; // output items still to come, oldest first

	// shared between the driver and the monitor
	int          cur_n_typed;
	logic [71:0] cur_pkt;
	int unsigned items_taken;
	int unsigned cycle_count;
	bit          failed;

	// receiver hold-off bookkeeping
	int unsigned hold_left;
	bit          hold_done;

	table_row_t  directed_rows [$];

	// frames a command into its packet, or counts one received reply byte
	function automatic void frame_packet_or_reply(input cmd_item_t it);
		byte_t       pkt [PKT_MAX];
		int unsigned n_bytes;
		int unsigned n_data;
		logic [1:0]  width;
		byte_t       sum;
		bus_item_t   r;
		step_items.delete();
		if (it.opcode == OP_UNUSED)
			return;
		if (it.opcode == OP_RX) begin
			// nothing armed: the byte is dropped
			if (reply_mode == MODE_NONE)
				return;
			if (reply_idx == 4'd2)
				seen_id = it.rx_data;
			if (reply_mode == MODE_READ && reply_idx == 4'd5)
				value_lo = it.rx_data;
			if (reply_mode == MODE_READ && reply_idx == 4'd6 && read_width == 2'd2)
				value_hi = it.rx_data;
			if ({1'b0, reply_idx} + 5'd1 >= {1'b0, reply_len}) begin
				// final reply byte: one report
				r = '0;
				r.reply_id = seen_id;
				if (reply_mode == MODE_READ) begin
					r.kind = KIND_READ;
					r.read_value = {(read_width == 2'd2) ? value_hi : 8'h00, value_lo};
					r.read_ok = (byte_t'(~reply_sum) == it.rx_data);
				end else begin
					r.kind = KIND_PING;
				end
				step_items.push_back(r);
				reply_mode = MODE_NONE;
				reply_idx = '0;
				reply_sum = '0;
				return;
			end
			// id up to the byte before the checksum is summed
			if (reply_idx >= 4'd2)
				reply_sum = reply_sum + it.rx_data;
			reply_idx = reply_idx + 4'd1;
			return;
		end

		// any command drops a pending reply
		reply_mode = MODE_NONE;
		reply_idx = '0;
		reply_sum = '0;

		pkt[0] = HEADER_BYTE;
		pkt[1] = HEADER_BYTE;
		pkt[2] = it.motor_id;
		case (it.opcode)
			OP_WRITE, OP_REG_WRITE: begin
				// a data count of three is clipped to two
				n_data = (it.param_count > 2'd2) ? 2 : int'(it.param_count);
				pkt[3] = byte_t'(3 + n_data);
				pkt[4] = (it.opcode == OP_WRITE) ? INSTR_WRITE : INSTR_REG_WRITE;
				pkt[5] = it.reg_addr;
				pkt[6] = it.param_lo;
				pkt[7] = it.param_hi;
				n_bytes = 7 + n_data;
			end
			OP_READ: begin
				// read count clipped into one or two bytes
				if (it.param_count == 2'd0)
					width = 2'd1;
				else if (it.param_count == 2'd3)
					width = 2'd2;
				else
					width = it.param_count;
				pkt[3] = 8'd4;
				pkt[4] = INSTR_READ;
				pkt[5] = it.reg_addr;
				pkt[6] = {6'd0, width};
				n_bytes = 8;
				reply_mode = MODE_READ;
				reply_len = 4'd6 + {2'd0, width};
				read_width = width;
				value_lo = '0;
				value_hi = '0;
			end
			OP_ACTION: begin
				pkt[3] = 8'd2;
				pkt[4] = INSTR_ACTION;
				n_bytes = 6;
			end
			OP_PING: begin
				pkt[3] = 8'd2;
				pkt[4] = INSTR_PING;
				n_bytes = 6;
				reply_mode = MODE_PING;
				reply_len = 4'd6;
			end
			default: begin
				pkt[3] = 8'd2;
				pkt[4] = INSTR_RESET;
				n_bytes = 6;
			end
		endcase

		// inverted sum from the id up to the byte before the checksum
		sum = '0;
		for (int i = 2; i + 1 < n_bytes; i++)
			sum = sum + pkt[i];
		pkt[n_bytes - 1] = ~sum;

		for (int i = 0; i < n_bytes; i++) begin
			r = '0;
			r.kind = KIND_TX;
			r.tx_byte = pkt[i];
			r.last = (i + 1 == n_bytes);
			step_items.push_back(r);
		end
	endfunction

	// one stretch with no idling on either side
	function automatic bit calm_window();
		return items_taken >= CALM_FROM && items_taken < CALM_TO;
	endfunction

	// ------------------------------------------------------------------------
	// monitor: model on input handshakes, compare on output handshakes
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		cmd_item_t acc;
		bus_item_t got;
		bus_item_t want;
		bus_item_t typed;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d output items still due", $time,
				bus_items_due.size());
			$display("testbench: FAIL");
			$finish;
		end else if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				items_taken++;
				acc.opcode = in_ch.opcode;
				acc.motor_id = in_ch.motor_id;
				acc.reg_addr = in_ch.reg_addr;
				acc.param_count = in_ch.param_count;
				acc.param_lo = in_ch.param_lo;
				acc.param_hi = in_ch.param_hi;
				acc.rx_data = in_ch.rx_data;
				frame_packet_or_reply(acc);
				if (cur_n_typed >= 0) begin
					// packet typed into the table stands in for the model
					for (int k = 0; k < cur_n_typed; k++) begin
						typed = '0;
						typed.kind = KIND_TX;
						typed.tx_byte = cur_pkt[8 * (cur_n_typed - 1 - k) +: 8];
						typed.last = (k == cur_n_typed - 1);
						bus_items_due.push_back(typed);
					end
				end else begin
					foreach (step_items[k])
						bus_items_due.push_back(step_items[k]);
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				got.kind = out_ch.kind;
				got.tx_byte = out_ch.tx_byte;
				got.last = out_ch.last;
				got.reply_id = out_ch.reply_id;
				got.read_value = out_ch.read_value;
				got.read_ok = out_ch.read_ok;
				if (bus_items_due.size() == 0) begin
					$display("%0t: output item with none due: expected nothing, got %h",
						$time, got);
					failed = 1'b1;
				end else begin
					want = bus_items_due.pop_front();
					if (got.kind !== want.kind) begin
						$display("%0t: kind expected %0d got %0d", $time, want.kind, got.kind);
						failed = 1'b1;
					end
					if (got.tx_byte !== want.tx_byte) begin
						$display("%0t: tx_byte expected %h got %h", $time,
							want.tx_byte, got.tx_byte);
						failed = 1'b1;
					end
					if (got.last !== want.last) begin
						$display("%0t: last expected %b got %b", $time, want.last, got.last);
						failed = 1'b1;
					end
					if (got.reply_id !== want.reply_id) begin
						$display("%0t: reply_id expected %h got %h", $time,
							want.reply_id, got.reply_id);
						failed = 1'b1;
					end
					if (got.read_value !== want.read_value) begin
						$display("%0t: read_value expected %h got %h", $time,
							want.read_value, got.read_value);
						failed = 1'b1;
					end
					if (got.read_ok !== want.read_ok) begin
						$display("%0t: read_ok expected %b got %b", $time,
							want.read_ok, got.read_ok);
						failed = 1'b1;
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// output side: random ready, one long hold-off, one calm stretch
	// ------------------------------------------------------------------------
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				out_ch.ready = 1'b0;
				hold_left--;
			end else if (!hold_done && items_taken >= HOLD_AT) begin
				// the framer fills up while the sender keeps offering items
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = calm_window() || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// ------------------------------------------------------------------------
	// input side
	// ------------------------------------------------------------------------

	// offer one item from a falling edge until it is taken
	task automatic send_item(input cmd_item_t it, input int n_typed,
		input logic [71:0] pkt);
		@(negedge clk);
		while (!calm_window() && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid = 1'b0;
			@(negedge clk);
		end
		in_ch.opcode = it.opcode;
		in_ch.motor_id = it.motor_id;
		in_ch.reg_addr = it.reg_addr;
		in_ch.param_count = it.param_count;
		in_ch.param_lo = it.param_lo;
		in_ch.param_hi = it.param_hi;
		in_ch.rx_data = it.rx_data;
		cur_n_typed = n_typed;
		cur_pkt = pkt;
		in_ch.valid = 1'b1;
		forever begin
			@(posedge clk);
			if (in_ch.ready)
				break;
		end
	endtask

	// all fields random, ids leaning toward the edge values now and then
	function automatic cmd_item_t random_item();
		cmd_item_t it;
		it.opcode = 3'($urandom_range(0, 7));
		case ($urandom_range(0, 19))
			0: it.motor_id = 8'h00;
			1: it.motor_id = ID_BCAST;
			2: it.motor_id = 8'hFF;
			default: it.motor_id = 8'($urandom);
		endcase
		it.reg_addr = 8'($urandom);
		it.param_count = 2'($urandom_range(0, 3));
		it.param_lo = 8'($urandom);
		it.param_hi = 8'($urandom);
		it.rx_data = 8'($urandom);
		return it;
	endfunction

	// one received bus byte, other fields random
	task automatic send_rx(input byte_t b);
		cmd_item_t it;
		it = random_item();
		it.opcode = OP_RX;
		it.rx_data = b;
		send_item(it, -1, '0);
	endtask

	task automatic add_row(input logic [2:0] op, input byte_t id, input byte_t addr,
		input logic [1:0] cnt, input byte_t lo, input byte_t hi, input byte_t rx,
		input int n_typed, input logic [71:0] pkt);
		table_row_t row;
		row.item = '{op, id, addr, cnt, lo, hi, rx};
		row.n_typed = n_typed;
		row.pkt = pkt;
		directed_rows.push_back(row);
	endtask

	initial begin
		cmd_item_t   it;
		int unsigned random_taken;
		int unsigned roll;
		int unsigned n_reply;
		int unsigned cut;
		logic [1:0]  width;
		bit          is_read;
		byte_t       reply [8];
		byte_t       sum;

		// everything driven from time zero
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.opcode = OP_WRITE;
		in_ch.motor_id = '0;
		in_ch.reg_addr = '0;
		in_ch.param_count = '0;
		in_ch.param_lo = '0;
		in_ch.param_hi = '0;
		in_ch.rx_data = '0;
		cur_n_typed = -1;
		cur_pkt = '0;
		items_taken = 0;
		cycle_count = 0;
		failed = 1'b0;
		hold_left = 0;
		hold_done = 1'b0;

		// bus model after reset: nothing armed, one-byte read width
		reply_mode = MODE_NONE;
		reply_idx = '0;
		reply_len = '0;
		reply_sum = '0;
		seen_id = '0;
		value_lo = '0;
		value_hi = '0;
		read_width = 2'd1;

		// stray received byte straight after reset: no output
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'h5A, 0, '0);
		// action to id 0
		add_row(OP_ACTION, 8'h00, 8'hFF, 2'd3, 8'hFF, 8'hFF, 8'hFF, 6,
			{HEADER_BYTE, HEADER_BYTE, 8'h00, 8'h02, INSTR_ACTION, 8'hF8});
		// reset to the broadcast id, sent unchanged
		add_row(OP_RESET, ID_BCAST, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00, 6,
			{HEADER_BYTE, HEADER_BYTE, ID_BCAST, 8'h02, INSTR_RESET, 8'hF9});
		// ping to id 255, sent like any other id, arms a ping reply
		add_row(OP_PING, 8'hFF, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00, 6,
			{HEADER_BYTE, HEADER_BYTE, 8'hFF, 8'h02, INSTR_PING, 8'hFD});
		// ping reply with edge byte values; checksum never checked
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'hFF, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'hFF, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'h02, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'hFF, -1, '0);
		// write with no data bytes
		add_row(OP_WRITE, 8'h01, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00, 7,
			{HEADER_BYTE, HEADER_BYTE, 8'h01, 8'h03, INSTR_WRITE, 8'h00, 8'hF8});
		// write with a data count of three, clipped to two
		add_row(OP_WRITE, 8'hFF, 8'hFF, 2'd3, 8'hFF, 8'hFF, 8'hFF, -1, '0);
		// reg write with two data bytes
		add_row(OP_REG_WRITE, ID_BCAST, 8'h1E, 2'd2, 8'h00, 8'h80, 8'h00, -1, '0);
		// read with count zero becomes a one-byte read, then a clean reply
		add_row(OP_READ, 8'h05, 8'h24, 2'd0, 8'h00, 8'h00, 8'h00, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'hFF, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'hFF, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'h05, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'h03, -1, '0);
		// unused opcode mid reply: no output, count unchanged
		add_row(OP_UNUSED, 8'h05, 8'h24, 2'd1, 8'h11, 8'h22, 8'h33, 0, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'h34, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'hC3, -1, '0);
		// read with count three becomes two bytes, cut short by an action
		add_row(OP_READ, 8'h07, 8'h2A, 2'd3, 8'h00, 8'h00, 8'h00, -1, '0);
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'hFF, -1, '0);
		add_row(OP_ACTION, 8'h07, 8'h00, 2'd0, 8'h00, 8'h00, 8'h00, -1, '0);
		// the rest of the cancelled reply is dropped
		add_row(OP_RX, 8'h00, 8'h00, 2'd0, 8'h00, 8'h00, 8'hFF, 0, '0);

		// hold reset, then release it on a falling edge
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_item(directed_rows[i].item, directed_rows[i].n_typed,
				directed_rows[i].pkt);

		// random part: commands, most read and ping commands followed by
		// their reply with random content
		random_taken = 0;
		while (random_taken < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				// stray item: unused opcode or a received byte between commands
				it = random_item();
				it.opcode = (roll < 3) ? OP_UNUSED : OP_RX;
				send_item(it, -1, '0);
				continue;
			end
			it = random_item();
			case ($urandom_range(0, 9))
				0, 1: it.opcode = OP_WRITE;
				2, 3: it.opcode = OP_READ;
				4:    it.opcode = OP_REG_WRITE;
				5:    it.opcode = OP_ACTION;
				6, 7: it.opcode = OP_PING;
				default: it.opcode = OP_RESET;
			endcase
			send_item(it, -1, '0);
			random_taken++;
			if (it.opcode != OP_READ && it.opcode != OP_PING)
				continue;

			is_read = (it.opcode == OP_READ);
			if (it.param_count == 2'd0)
				width = 2'd1;
			else if (it.param_count == 2'd3)
				width = 2'd2;
			else
				width = it.param_count;
			n_reply = is_read ? 6 + width : 6;

			// status reply: headers, id, length, error, data, checksum
			reply[0] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : HEADER_BYTE;
			reply[1] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : HEADER_BYTE;
			reply[2] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : it.motor_id;
			reply[3] = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'(n_reply - 4);
			reply[4] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
			for (int k = 5; k < 8; k++)
				reply[k] = 8'($urandom);
			sum = '0;
			for (int k = 2; k + 1 < n_reply; k++)
				sum = sum + reply[k];
			if ($urandom_range(0, 3) != 0)
				reply[n_reply - 1] = ~sum;

			// now and then the reply stops short and the next command cancels it
			cut = ($urandom_range(0, 99) < 12) ? $urandom_range(0, n_reply - 1) : n_reply;
			for (int k = 0; k < cut; k++) begin
				if ($urandom_range(0, 99) < 4) begin
					it = random_item();
					it.opcode = OP_UNUSED;
					send_item(it, -1, '0);
				end
				send_rx(reply[k]);
				random_taken++;
			end
		end

		@(negedge clk);
		in_ch.valid = 1'b0;

		// drain, then give the framer time to show anything extra
		while (bus_items_due.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (bus_items_due.size() != 0) begin
			$display("%0t: %0d output items never arrived", $time, bus_items_due.size());
			failed = 1'b1;
		end
		if (!failed) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+sv
sv/sbpf_pkg.sv
sv/sbpf_in_if.sv
sv/sbpf_out_if.sv
sv/servo_bus_packet_framer.sv
tb/testbench.sv
